FILE: hw/rtl/eohp_pkg.sv
// Shared types, constants and helpers of the eCPRI / O-RAN header parser.
package eohp_pkg;

    // Widths of the record fields and of the parser state.
    localparam int unsigned FID_W    = 5;
    localparam int unsigned VALUE_W  = 56;
    localparam int unsigned FRAME_W  = 16;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned WIN_W    = 64;
    localparam int unsigned WIN_BYTES = 8;
    localparam int unsigned MAX_REC  = 3;
    localparam int unsigned SUB_W    = 2;
    localparam int unsigned FILL_W   = 4;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned HDR_BYTES = 30;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic        REG_IDX_SYNC_PATTERN = 1'b0;
    localparam logic [63:0] SYNC_RESET = 64'hFB55_5555_5555_55D5;

    // Record identifiers.
    typedef enum logic [4:0] {
        FID_PREAMBLE     = 5'd0,
        FID_SFD          = 5'd1,
        FID_DST_MAC      = 5'd2,
        FID_SRC_MAC      = 5'd3,
        FID_ETHERTYPE    = 5'd4,
        FID_ECPRI_REV    = 5'd5,
        FID_ECPRI_RSVD   = 5'd6,
        FID_ECPRI_CONCAT = 5'd7,
        FID_MSG_TYPE     = 5'd8,
        FID_PAYLOAD_SIZE = 5'd9,
        FID_RTC_PC_ID    = 5'd10,
        FID_SEQ_ID       = 5'd11,
        FID_DATA_DIR     = 5'd12,
        FID_PAYLOAD_VER  = 5'd13,
        FID_FILTER_IDX   = 5'd14,
        FID_FRAME_ID     = 5'd15,
        FID_SUBFRAME_ID  = 5'd16,
        FID_SLOT_ID      = 5'd17,
        FID_SYMBOL_ID    = 5'd18,
        FID_SECTION_ID   = 5'd19,
        FID_RB           = 5'd20,
        FID_SYM_INC      = 5'd21,
        FID_START_PRB    = 5'd22,
        FID_NUM_PRB      = 5'd23
    } fid_t;

    // Header byte positions on which records complete.
    localparam logic [4:0] POS_DST_MAC   = 5'd5;
    localparam logic [4:0] POS_SRC_MAC   = 5'd11;
    localparam logic [4:0] POS_ETHERTYPE = 5'd13;
    localparam logic [4:0] POS_ECPRI_B0  = 5'd14;
    localparam logic [4:0] POS_MSG_TYPE  = 5'd15;
    localparam logic [4:0] POS_PAY_SIZE  = 5'd17;
    localparam logic [4:0] POS_RTC_PC    = 5'd19;
    localparam logic [4:0] POS_SEQ_ID    = 5'd21;
    localparam logic [4:0] POS_ORAN_B0   = 5'd22;
    localparam logic [4:0] POS_FRAME_ID  = 5'd23;
    localparam logic [4:0] POS_SUBFRAME  = 5'd24;
    localparam logic [4:0] POS_SLOT_SYM  = 5'd25;
    localparam logic [4:0] POS_SECTION   = 5'd27;
    localparam logic [4:0] POS_START_PRB = 5'd28;
    localparam logic [4:0] POS_NUM_PRB   = 5'd29;

    // One record without its frame number.
    typedef struct packed {
        fid_t               id;
        logic [VALUE_W-1:0] value;
        logic               hend;
    } rec_t;

    // All records caused by one input word.
    typedef struct packed {
        logic [SUB_W-1:0]   cnt;
        logic [FRAME_W-1:0] frame;
        rec_t [MAX_REC-1:0] rec;
    } group_t;

    function automatic rec_t make_rec(fid_t id, logic [VALUE_W-1:0] value, logic hend);
        rec_t r;
        r.id    = id;
        r.value = value;
        r.hend  = hend;
        return r;
    endfunction

endpackage

FILE: hw/rtl/eohp_byte_if.sv
// Byte stream channel: valid, ready and one data byte.
interface eohp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/eohp_rec_if.sv
// Record channel: valid, ready and one parsed header field.
interface eohp_rec_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [55:0] field_value;
    logic [15:0] frame_number;
    logic        header_end;
    logic        last;

    modport source (output valid, output field_id, output field_value,
                    output frame_number, output header_end, output last, input ready);
    modport sink (input valid, input field_id, input field_value,
                  input frame_number, input header_end, input last, output ready);
endinterface

FILE: hw/rtl/ecpri_oran_header_parser.sv
// Top level of the eCPRI / O-RAN uplane header parser.
// A byte's records are registered in the group queue and offered once earlier groups are sent.
// Throughput: one byte per cycle; up to three records per byte, one per cycle while ready.
// The group queue (QUEUE_DEPTH entries) absorbs bursts; ready drops only while it is full.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the parser state
// to hunting with an empty window and restores the start pattern to its default.
module ecpri_oran_header_parser #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eohp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [eohp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [eohp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    eohp_byte_if.sink                        stream,
    eohp_rec_if.source                       record
);

    logic [eohp_pkg::WIN_W-1:0] sync_pattern;
    logic                       can_push;
    logic                       accept;
    logic                       push;
    eohp_pkg::group_t           group;

    // Bytes are taken whenever the queue has room for one more group.
    assign stream.ready = can_push;
    assign accept       = stream.valid && can_push;

    // Configuration register.
    eohp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sync_pattern (sync_pattern)
    );

    // Pattern hunt and field extraction.
    eohp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (stream.data_byte),
        .sync_pattern (sync_pattern),
        .push         (push),
        .group        (group)
    );

    // Record queue and output serializer.
    eohp_recq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_recq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .group    (group),
        .can_push (can_push),
        .record   (record)
    );

endmodule

FILE: hw/rtl/eohp_cfg.sv
// APB-style register holding the start pattern.
module eohp_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [eohp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [eohp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [eohp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [eohp_pkg::WIN_W-1:0]           sync_pattern
);

    logic [eohp_pkg::WIN_W-1:0] pattern_reg;
    logic                       sel_sync;

    // Registers sit on eight-byte boundaries; the top address bit picks the register.
    assign sel_sync = (paddr[eohp_pkg::CFG_ADDR_W-1] == eohp_pkg::REG_IDX_SYNC_PATTERN);
    assign pready   = 1'b1;

    // Write on the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= eohp_pkg::SYNC_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_sync)
        begin
            pattern_reg <= pwdata;
        end
    end

    // Read back; addresses beyond the register list read as zero.
    assign prdata       = sel_sync ? pattern_reg : '0;
    assign sync_pattern = pattern_reg;

endmodule

FILE: hw/rtl/eohp_parser.sv
// Start pattern hunter and header field extractor, one byte per cycle while accept is high.
module eohp_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic [eohp_pkg::WIN_W-1:0] sync_pattern,
    output logic                       push,
    output eohp_pkg::group_t           group
);

    logic [eohp_pkg::WIN_W-1:0]   win_reg, win_next;
    logic [eohp_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic                         in_hdr_reg, in_hdr_next;
    logic [eohp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [eohp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [eohp_pkg::FRAME_W-1:0] frame_reg, frame_next;

    logic [eohp_pkg::WIN_W-1:0]   win_shift;
    logic [eohp_pkg::ACC_W-1:0]   acc_shift;
    logic [7:0]                   prev;
    logic [eohp_pkg::IDX_W-1:0]   idx_inc;
    logic                         match;

    // Shifted views of the window and the accumulator.
    assign win_shift = {win_reg[eohp_pkg::WIN_W-9:0], data_byte};
    assign acc_shift = {acc_reg[eohp_pkg::ACC_W-9:0], data_byte};
    assign prev      = acc_reg[7:0];
    assign idx_inc   = idx_reg + 1'b1;
    assign match     = (fill_reg >= eohp_pkg::FILL_W'(eohp_pkg::WIN_BYTES - 1))
                       && (win_shift == sync_pattern);

    // Next state and the records caused by the accepted byte.
    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        in_hdr_next = in_hdr_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        frame_next  = frame_reg;
        group       = '0;
        group.frame = frame_reg;

        if (in_hdr_reg)
        begin
            acc_next = acc_shift;
            unique case (idx_reg)
                eohp_pkg::POS_DST_MAC:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_DST_MAC,
                                                      56'(acc_shift), 1'b0);
                end
                eohp_pkg::POS_SRC_MAC:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_SRC_MAC,
                                                      56'(acc_shift), 1'b0);
                end
                eohp_pkg::POS_ETHERTYPE:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_ETHERTYPE,
                                                      56'(acc_shift[15:0]), 1'b0);
                end
                eohp_pkg::POS_ECPRI_B0:
                begin
                    group.cnt    = 2'd3;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_ECPRI_REV,
                                                      56'(data_byte[7:4]), 1'b0);
                    group.rec[1] = eohp_pkg::make_rec(eohp_pkg::FID_ECPRI_RSVD,
                                                      56'(data_byte[3:1]), 1'b0);
                    group.rec[2] = eohp_pkg::make_rec(eohp_pkg::FID_ECPRI_CONCAT,
                                                      56'(data_byte[0]), 1'b0);
                end
                eohp_pkg::POS_MSG_TYPE:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_MSG_TYPE,
                                                      56'(data_byte), 1'b0);
                end
                eohp_pkg::POS_PAY_SIZE:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_PAYLOAD_SIZE,
                                                      56'(acc_shift[15:0]), 1'b0);
                end
                eohp_pkg::POS_RTC_PC:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_RTC_PC_ID,
                                                      56'(acc_shift[15:0]), 1'b0);
                end
                eohp_pkg::POS_SEQ_ID:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_SEQ_ID,
                                                      56'(acc_shift[15:0]), 1'b0);
                end
                eohp_pkg::POS_ORAN_B0:
                begin
                    group.cnt    = 2'd3;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_DATA_DIR,
                                                      56'(data_byte[7]), 1'b0);
                    group.rec[1] = eohp_pkg::make_rec(eohp_pkg::FID_PAYLOAD_VER,
                                                      56'(data_byte[6:4]), 1'b0);
                    group.rec[2] = eohp_pkg::make_rec(eohp_pkg::FID_FILTER_IDX,
                                                      56'(data_byte[3:0]), 1'b0);
                end
                eohp_pkg::POS_FRAME_ID:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_FRAME_ID,
                                                      56'(data_byte), 1'b0);
                end
                eohp_pkg::POS_SUBFRAME:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_SUBFRAME_ID,
                                                      56'(data_byte[7:4]), 1'b0);
                end
                eohp_pkg::POS_SLOT_SYM:
                begin
                    group.cnt    = 2'd2;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_SLOT_ID,
                                                      56'({prev[3:0], data_byte[7:6]}), 1'b0);
                    group.rec[1] = eohp_pkg::make_rec(eohp_pkg::FID_SYMBOL_ID,
                                                      56'(data_byte[5:0]), 1'b0);
                end
                eohp_pkg::POS_SECTION:
                begin
                    group.cnt    = 2'd3;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_SECTION_ID,
                                                      56'({prev, data_byte[7:4]}), 1'b0);
                    group.rec[1] = eohp_pkg::make_rec(eohp_pkg::FID_RB,
                                                      56'(data_byte[3]), 1'b0);
                    group.rec[2] = eohp_pkg::make_rec(eohp_pkg::FID_SYM_INC,
                                                      56'(data_byte[2]), 1'b0);
                end
                eohp_pkg::POS_START_PRB:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_START_PRB,
                                                      56'({prev[1:0], data_byte}), 1'b0);
                end
                eohp_pkg::POS_NUM_PRB:
                begin
                    group.cnt    = 2'd1;
                    group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_NUM_PRB,
                                                      56'(data_byte), 1'b1);
                end
                default:
                begin
                    group.cnt = 2'd0;
                end
            endcase

            // Past the last header byte, go back to hunting with an empty window.
            if (idx_inc >= eohp_pkg::IDX_W'(eohp_pkg::HDR_BYTES))
            begin
                in_hdr_next = 1'b0;
                idx_next    = '0;
                win_next    = '0;
                fill_next   = '0;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end
        else
        begin
            win_next = win_shift;
            if (fill_reg != eohp_pkg::FILL_W'(eohp_pkg::WIN_BYTES))
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (match)
            begin
                frame_next   = frame_reg + 1'b1;
                group.frame  = frame_reg + 1'b1;
                group.cnt    = 2'd2;
                group.rec[0] = eohp_pkg::make_rec(eohp_pkg::FID_PREAMBLE,
                                                  win_shift[eohp_pkg::WIN_W-1:8], 1'b0);
                group.rec[1] = eohp_pkg::make_rec(eohp_pkg::FID_SFD,
                                                  56'(data_byte), 1'b0);
                win_next     = '0;
                fill_next    = '0;
                in_hdr_next  = 1'b1;
                idx_next     = '0;
                acc_next     = '0;
            end
        end
    end

    assign push = accept && (group.cnt != 2'd0);

    // State advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            fill_reg   <= '0;
            in_hdr_reg <= 1'b0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            frame_reg  <= '0;
        end
        else if (accept)
        begin
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            in_hdr_reg <= in_hdr_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

FILE: hw/rtl/eohp_recq.sv
// Queue of record groups, drained one record per output word.
module eohp_recq #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eohp_pkg::group_t  group,
    output logic              can_push,
    eohp_rec_if.source        record
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    eohp_pkg::group_t            q_reg [DEPTH];
    logic [PW-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]               count_reg;
    logic [eohp_pkg::SUB_W-1:0]  sub_reg;

    eohp_pkg::group_t            head;
    eohp_pkg::rec_t              cur;
    logic                        take;
    logic                        pop;
    logic                        is_last;

    assign can_push = (count_reg != CW'(DEPTH));
    assign head     = q_reg[rd_ptr_reg];
    assign cur      = head.rec[sub_reg];
    assign is_last  = (sub_reg == (head.cnt - 1'b1));
    assign take     = record.valid && record.ready;
    assign pop      = take && is_last;

    // Present the current record of the head group.
    assign record.valid        = (count_reg != '0);
    assign record.field_id     = cur.id;
    assign record.field_value  = cur.value;
    assign record.frame_number = head.frame;
    assign record.header_end   = cur.hend;
    assign record.last         = is_last;

    // Group storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= group;
        end
    end

    // Pointers, fill count and position within the head group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                if (is_last)
                begin
                    sub_reg    <= '0;
                    rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                end
                else
                begin
                    sub_reg <= sub_reg + 1'b1;
                end
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("record queue count exceeds depth");

    // No group is written into a full queue unless a group leaves it in the same cycle.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)) || pop)
        else $error("record queue written while full");

    // A queued group always holds at least one record, and the pointer stays inside it.
    a_sub_inside: assert property (@(posedge clk) disable iff (!rst_n)
        record.valid |-> (head.cnt != '0) && (sub_reg < head.cnt))
        else $error("record index outside head group");

    // Between words of a group the index only moves on a taken word.
    a_sub_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(sub_reg))
        else $error("record index moved without a transfer");
`endif

endmodule
